/* rtl/ftr_pkg.sv */
// shared types, constants and saturating helpers for the frame timestamp repair block
package ftr_pkg;

   localparam int TB_W      = 31;
   localparam int RATE_W    = 20;
   localparam int TICK_W    = 63;
   localparam int DTICK_W   = 32;
   localparam int SAMP_W    = 16;
   localparam int NS_W      = 64;
   localparam int CSR_IDX_W = 3;

   localparam int NS_CONST_W = 30;
   localparam logic [NS_CONST_W-1:0] NS_PER_S = 30'd1000000000;

   localparam int MPLR_W   = 62;
   localparam int ACC_HI_W = 63;
   localparam int DV_HI_W  = 61;
   localparam int CNT_W    = 5;
   localparam logic [CNT_W-1:0] MUL_LAST = 5'd30;
   localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

   localparam logic [TB_W-1:0]   RST_VIDEO_TB_NUM = 31'd1;
   localparam logic [TB_W-1:0]   RST_VIDEO_TB_DEN = 31'd90000;
   localparam logic [TB_W-1:0]   RST_AUDIO_TB_NUM = 31'd1;
   localparam logic [TB_W-1:0]   RST_AUDIO_TB_DEN = 31'd48000;
   localparam logic [RATE_W-1:0] RST_AUDIO_RATE   = 20'd48000;

   localparam logic MODE_VIDEO = 1'b0;
   localparam logic MODE_AUDIO = 1'b1;

   localparam logic signed [NS_W-1:0] NS_SAT_MAX = {1'b0, {(NS_W-1){1'b1}}};
   localparam logic signed [NS_W-1:0] NS_SAT_MIN = {1'b1, {(NS_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIDEO_TB_NUM  = 3'd0,
      CSR_VIDEO_TB_DEN  = 3'd1,
      CSR_AUDIO_TB_NUM  = 3'd2,
      CSR_AUDIO_TB_DEN  = 3'd3,
      CSR_AUDIO_RATE    = 3'd4
   } ftr_csr_idx_type;

   typedef struct packed {
      logic [TB_W-1:0]   video_tb_num;
      logic [TB_W-1:0]   video_tb_den;
      logic [TB_W-1:0]   audio_tb_num;
      logic [TB_W-1:0]   audio_tb_den;
      logic [RATE_W-1:0] audio_sample_rate;
   } ftr_cfg_type;

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] mag;
      logic [TB_W-1:0]   num;
      logic [TB_W-1:0]   den;
   } ftr_md_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [NS_W-1:0] quot;
   } ftr_md_rsp_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MUL,
      MD_ROUND,
      MD_CHECK,
      MD_DIV,
      MD_DONE
   } ftr_md_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PTS,
      ST_PTS_WAIT,
      ST_DUR,
      ST_DUR_WAIT,
      ST_NEXT
   } ftr_state_type;

   function automatic logic signed [NS_W-1:0] sign_sat(input logic neg,
                                                       input logic [NS_W-1:0] q);
      logic signed [NS_W-1:0] r;
      if (q[NS_W-1]) begin
         r = neg ? NS_SAT_MIN : NS_SAT_MAX;
      end else begin
         r = neg ? -$signed(q) : $signed(q);
      end
      return r;
   endfunction

   function automatic logic signed [NS_W-1:0] sat_add(input logic signed [NS_W-1:0] a,
                                                      input logic signed [NS_W-1:0] b);
      logic signed [NS_W-1:0] r;
      r = a + b;
      if ((a[NS_W-1] == b[NS_W-1]) && (r[NS_W-1] != a[NS_W-1])) begin
         r = a[NS_W-1] ? NS_SAT_MIN : NS_SAT_MAX;
      end
      return r;
   endfunction

   function automatic logic signed [NS_W-1:0] sat_sub(input logic signed [NS_W-1:0] a,
                                                      input logic signed [NS_W-1:0] b);
      logic signed [NS_W-1:0] r;
      r = a - b;
      if ((a[NS_W-1] != b[NS_W-1]) && (r[NS_W-1] != a[NS_W-1])) begin
         r = a[NS_W-1] ? NS_SAT_MIN : NS_SAT_MAX;
      end
      return r;
   endfunction

endpackage

/* rtl/ftr_chan_if.sv */
// request and response channel interfaces with valid/ready handshake
interface ftr_req_if;
   import ftr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic                     ts_known;
   logic signed [TICK_W-1:0] ts_ticks;
   logic [DTICK_W-1:0]       dur_ticks;
   logic [SAMP_W-1:0]        sample_count;

   modport source (output valid, mode, ts_known, ts_ticks, dur_ticks, sample_count,
                   input ready);
   modport sink   (input valid, mode, ts_known, ts_ticks, dur_ticks, sample_count,
                   output ready);
endinterface

interface ftr_rsp_if;
   import ftr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [NS_W-1:0] pts_ns;
   logic                   pts_valid;
   logic signed [NS_W-1:0] dur_ns;

   modport source (output valid, pts_ns, pts_valid, dur_ns, input ready);
   modport sink   (input valid, pts_ns, pts_valid, dur_ns, output ready);
endinterface

/* rtl/frame_timestamp_repair.sv */
// top level of the frame timestamp repair block: sequencer, stream history, result register
//
// req_ch carries one frame timing record per transaction (valid/ready): mode selects
// video or audio, ts_known flags ts_ticks, dur_ticks and sample_count feed the duration.
// rsp_ch returns one transaction per record: pts_ns, pts_valid and dur_ns.
// csr_we/csr_index/csr_wdata write the time bases and the audio sample rate; write only
// while no record is in flight.
// each rescale runs on one shared serial unit: 2-bit multiply digits, a rounding step,
// an overflow check, 2-bit quotient digits and a done state; the quotient digits are
// skipped when the quotient saturates.
// a record needs zero, one or two rescales; the next request can be taken in the same
// cycle as the response is presented.
// reset clears the sequencer, the stream history (no prediction, no previous frame,
// previous duration zero) and the configuration to its default time bases.
// a finished response waits in the output register; a new request is accepted while
// it waits, and only the final commit of the next record holds until rsp_ch is free.
module frame_timestamp_repair (
   input  logic                          clock,
   input  logic                          reset,
   ftr_req_if.sink                       req_ch,
   ftr_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [ftr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ftr_pkg::TB_W-1:0]      csr_wdata
);
   import ftr_pkg::*;

   ftr_cfg_type    cfg;
   ftr_md_req_type md_req;
   ftr_md_rsp_type md_rsp;

   ftr_state_type state_ff, state_in;

   logic                   audio_ff, audio_in;
   logic                   known_ff, known_in;
   logic [TICK_W-1:0]      ticks_ff, ticks_in;
   logic [DTICK_W-1:0]     dticks_ff, dticks_in;
   logic [SAMP_W-1:0]      samples_ff, samples_in;
   logic signed [NS_W-1:0] pts_ff, pts_in;
   logic                   valid_ff, valid_in;
   logic signed [NS_W-1:0] dur_ff, dur_in;

   logic signed [NS_W-1:0] vid_next_ts_ff, vid_next_ts_in;
   logic                   vid_next_valid_ff, vid_next_valid_in;
   logic signed [NS_W-1:0] vid_prev_ts_ff, vid_prev_ts_in;
   logic                   vid_prev_valid_ff, vid_prev_valid_in;
   logic signed [NS_W-1:0] vid_prev_dur_ff, vid_prev_dur_in;
   logic signed [NS_W-1:0] aud_next_ts_ff, aud_next_ts_in;
   logic                   aud_next_valid_ff, aud_next_valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [NS_W-1:0] rsp_pts_ff, rsp_pts_in;
   logic                   rsp_pts_valid_ff, rsp_pts_valid_in;
   logic signed [NS_W-1:0] rsp_dur_ff, rsp_dur_in;

   logic [TB_W-1:0]        num_sel;
   logic [TB_W-1:0]        den_sel;
   logic [TICK_W-1:0]      mag;
   logic                   dur_use_unit;
   logic                   prev_dur_pos;
   logic                   out_free;
   logic signed [NS_W-1:0] next_ts;

   ftr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ftr_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      num_sel = (audio_ff == MODE_AUDIO) ? cfg.audio_tb_num : cfg.video_tb_num;
      den_sel = (audio_ff == MODE_AUDIO) ? cfg.audio_tb_den : cfg.video_tb_den;
      if (den_sel == '0) begin
         den_sel = TB_W'(1);
      end
      mag          = ticks_ff[TICK_W-1] ? (TICK_W'(0) - ticks_ff) : ticks_ff;
      prev_dur_pos = !vid_prev_dur_ff[NS_W-1] && (vid_prev_dur_ff != '0);
      if (audio_ff == MODE_AUDIO) begin
         dur_use_unit = cfg.audio_sample_rate != '0;
      end else begin
         dur_use_unit = (dticks_ff != '0)
                        || (!(vid_prev_valid_ff && valid_ff) && !prev_dur_pos);
      end
      out_free = !rsp_valid_ff || rsp_ch.ready;
      next_ts  = valid_ff ? sat_add(pts_ff, dur_ff) : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_ch.valid) state_in = ST_PTS;
         ST_PTS:      state_in = known_ff ? ST_PTS_WAIT : ST_DUR;
         ST_PTS_WAIT: if (md_rsp.done) state_in = ST_DUR;
         ST_DUR:      state_in = dur_use_unit ? ST_DUR_WAIT : ST_NEXT;
         ST_DUR_WAIT: if (md_rsp.done) state_in = ST_NEXT;
         ST_NEXT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      audio_in          = audio_ff;
      known_in          = known_ff;
      ticks_in          = ticks_ff;
      dticks_in         = dticks_ff;
      samples_in        = samples_ff;
      pts_in            = pts_ff;
      valid_in          = valid_ff;
      dur_in            = dur_ff;
      vid_next_ts_in    = vid_next_ts_ff;
      vid_next_valid_in = vid_next_valid_ff;
      vid_prev_ts_in    = vid_prev_ts_ff;
      vid_prev_valid_in = vid_prev_valid_ff;
      vid_prev_dur_in   = vid_prev_dur_ff;
      aud_next_ts_in    = aud_next_ts_ff;
      aud_next_valid_in = aud_next_valid_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_pts_in        = rsp_pts_ff;
      rsp_pts_valid_in  = rsp_pts_valid_ff;
      rsp_dur_in        = rsp_dur_ff;
      md_req.start      = 1'b0;
      md_req.mag        = mag;
      md_req.num        = num_sel;
      md_req.den        = den_sel;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               audio_in   = req_ch.mode;
               known_in   = req_ch.ts_known;
               ticks_in   = req_ch.ts_ticks;
               dticks_in  = req_ch.dur_ticks;
               samples_in = req_ch.sample_count;
            end
         end
         ST_PTS: begin
            if (known_ff) begin
               md_req.start = 1'b1;
            end else if (audio_ff == MODE_AUDIO) begin
               pts_in   = aud_next_valid_ff ? aud_next_ts_ff : '0;
               valid_in = aud_next_valid_ff;
            end else begin
               pts_in   = vid_next_valid_ff ? vid_next_ts_ff : '0;
               valid_in = vid_next_valid_ff;
            end
         end
         ST_PTS_WAIT: begin
            if (md_rsp.done) begin
               pts_in   = sign_sat(ticks_ff[TICK_W-1], md_rsp.quot);
               valid_in = 1'b1;
            end
         end
         ST_DUR: begin
            if (audio_ff == MODE_AUDIO) begin
               md_req.mag = {{(TICK_W-SAMP_W){1'b0}}, samples_ff};
               md_req.num = TB_W'(1);
               md_req.den = {{(TB_W-RATE_W){1'b0}}, cfg.audio_sample_rate};
               if (dur_use_unit) begin
                  md_req.start = 1'b1;
               end else begin
                  dur_in = '0;
               end
            end else begin
               if (dticks_ff != '0) begin
                  md_req.mag = {{(TICK_W-DTICK_W){1'b0}}, dticks_ff};
               end else begin
                  md_req.mag = TICK_W'(1);
               end
               if (dur_use_unit) begin
                  md_req.start = 1'b1;
               end else if (vid_prev_valid_ff && valid_ff) begin
                  dur_in = sat_sub(pts_ff, vid_prev_ts_ff);
               end else begin
                  dur_in = vid_prev_dur_ff;
               end
            end
         end
         ST_DUR_WAIT: begin
            if (md_rsp.done) begin
               dur_in = sign_sat(1'b0, md_rsp.quot);
            end
         end
         ST_NEXT: begin
            if (out_free) begin
               if (audio_ff == MODE_AUDIO) begin
                  aud_next_ts_in    = next_ts;
                  aud_next_valid_in = valid_ff;
               end else begin
                  vid_prev_dur_in   = dur_ff;
                  vid_prev_ts_in    = valid_ff ? pts_ff : '0;
                  vid_prev_valid_in = valid_ff;
                  vid_next_ts_in    = next_ts;
                  vid_next_valid_in = valid_ff;
               end
               rsp_valid_in     = 1'b1;
               rsp_pts_in       = valid_ff ? pts_ff : '0;
               rsp_pts_valid_in = valid_ff;
               rsp_dur_in       = dur_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         vid_next_ts_ff    <= '0;
         vid_next_valid_ff <= 1'b0;
         vid_prev_ts_ff    <= '0;
         vid_prev_valid_ff <= 1'b0;
         vid_prev_dur_ff   <= '0;
         aud_next_ts_ff    <= '0;
         aud_next_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         vid_next_ts_ff    <= vid_next_ts_in;
         vid_next_valid_ff <= vid_next_valid_in;
         vid_prev_ts_ff    <= vid_prev_ts_in;
         vid_prev_valid_ff <= vid_prev_valid_in;
         vid_prev_dur_ff   <= vid_prev_dur_in;
         aud_next_ts_ff    <= aud_next_ts_in;
         aud_next_valid_ff <= aud_next_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      audio_ff         <= audio_in;
      known_ff         <= known_in;
      ticks_ff         <= ticks_in;
      dticks_ff        <= dticks_in;
      samples_ff       <= samples_in;
      pts_ff           <= pts_in;
      valid_ff         <= valid_in;
      dur_ff           <= dur_in;
      rsp_pts_ff       <= rsp_pts_in;
      rsp_pts_valid_ff <= rsp_pts_valid_in;
      rsp_dur_ff       <= rsp_dur_in;
   end

   assign req_ch.ready     = state_ff == ST_IDLE;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pts_ns    = rsp_pts_ff;
   assign rsp_ch.pts_valid = rsp_pts_valid_ff;
   assign rsp_ch.dur_ns    = rsp_dur_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff == ST_PTS_WAIT || state_ff == ST_DUR_WAIT))
      else $error("rescale result arrived outside a wait state");

   a_start_unit_idle: assert property (@(posedge clock) disable iff (reset)
      md_req.start |-> !md_rsp.busy)
      else $error("rescale started while the unit is busy");

   a_ready_unit_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !md_rsp.busy)
      else $error("request taken while a rescale is in progress");

   a_unknown_pts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pts_valid_ff) |-> (rsp_pts_ff == '0))
      else $error("unknown timestamp carries a nonzero value");
`endif

endmodule

/* rtl/ftr_csr.sv */
// configuration register file for time bases and audio sample rate
module ftr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ftr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ftr_pkg::TB_W-1:0]      csr_wdata,
   output ftr_pkg::ftr_cfg_type          cfg
);
   import ftr_pkg::*;

   ftr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VIDEO_TB_NUM: cfg_in.video_tb_num      = csr_wdata;
            CSR_VIDEO_TB_DEN: cfg_in.video_tb_den      = csr_wdata;
            CSR_AUDIO_TB_NUM: cfg_in.audio_tb_num      = csr_wdata;
            CSR_AUDIO_TB_DEN: cfg_in.audio_tb_den      = csr_wdata;
            CSR_AUDIO_RATE:   cfg_in.audio_sample_rate = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.video_tb_num      <= RST_VIDEO_TB_NUM;
         cfg_ff.video_tb_den      <= RST_VIDEO_TB_DEN;
         cfg_ff.audio_tb_num      <= RST_AUDIO_TB_NUM;
         cfg_ff.audio_tb_den      <= RST_AUDIO_TB_DEN;
         cfg_ff.audio_sample_rate <= RST_AUDIO_RATE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ftr_muldiv.sv */
// serial unit for round(mag * num * 1e9 / den), radix-4 multiply then radix-4 divide
module ftr_muldiv (
   input  logic                    clock,
   input  logic                    reset,
   input  ftr_pkg::ftr_md_req_type md_req,
   output ftr_pkg::ftr_md_rsp_type md_rsp
);
   import ftr_pkg::*;

   ftr_md_state_type     state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TICK_W-1:0]    mag_ff, mag_in;
   logic [TICK_W+1:0]    mag3_ff, mag3_in;
   logic [MPLR_W-1:0]    mplr_ff, mplr_in;
   logic [ACC_HI_W-1:0]  acc_hi_ff, acc_hi_in;
   logic [MPLR_W-1:0]    acc_lo_ff, acc_lo_in;
   logic [TB_W-1:0]      den_ff, den_in;
   logic [DV_HI_W-1:0]   dv_hi_ff, dv_hi_in;
   logic [NS_W-1:0]      dv_lo_ff, dv_lo_in;
   logic [TB_W-1:0]      rem_ff, rem_in;

   logic [TICK_W+1:0]    partial;
   logic [TICK_W+1:0]    mul_sum;
   logic [ACC_HI_W+MPLR_W-1:0] dsum;
   logic                 sat;
   logic [TB_W:0]        t1, t2;
   logic                 ge1, ge2;
   logic [TB_W-1:0]      r1, r2;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE:  if (md_req.start) state_in = MD_MUL;
         MD_MUL:   if (cnt_ff == MUL_LAST) state_in = MD_ROUND;
         MD_ROUND: state_in = MD_CHECK;
         MD_CHECK: state_in = sat ? MD_DONE : MD_DIV;
         MD_DIV:   if (cnt_ff == DIV_LAST) state_in = MD_DONE;
         MD_DONE:  state_in = MD_IDLE;
         default:  state_in = MD_IDLE;
      endcase
   end

   always_comb begin
      case (mplr_ff[1:0])
         2'd0:    partial = '0;
         2'd1:    partial = {2'b00, mag_ff};
         2'd2:    partial = {1'b0, mag_ff, 1'b0};
         default: partial = mag3_ff;
      endcase
      mul_sum = {2'b00, acc_hi_ff} + partial;
      dsum    = {acc_hi_ff, acc_lo_ff} + {{(ACC_HI_W+MPLR_W-TB_W+1){1'b0}}, den_ff[TB_W-1:1]};
      sat     = dv_hi_ff >= {{(DV_HI_W-TB_W){1'b0}}, den_ff};
      t1      = {rem_ff, dv_lo_ff[NS_W-1]};
      ge1     = t1 >= {1'b0, den_ff};
      r1      = ge1 ? TB_W'(t1 - {1'b0, den_ff}) : t1[TB_W-1:0];
      t2      = {r1, dv_lo_ff[NS_W-2]};
      ge2     = t2 >= {1'b0, den_ff};
      r2      = ge2 ? TB_W'(t2 - {1'b0, den_ff}) : t2[TB_W-1:0];
   end

   always_comb begin
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      mag3_in   = mag3_ff;
      mplr_in   = mplr_ff;
      acc_hi_in = acc_hi_ff;
      acc_lo_in = acc_lo_ff;
      den_in    = den_ff;
      dv_hi_in  = dv_hi_ff;
      dv_lo_in  = dv_lo_ff;
      rem_in    = rem_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mag_in    = md_req.mag;
               mag3_in   = {2'b00, md_req.mag} + {1'b0, md_req.mag, 1'b0};
               mplr_in   = {{(MPLR_W-TB_W){1'b0}}, md_req.num}
                           * {{(MPLR_W-NS_CONST_W){1'b0}}, NS_PER_S};
               acc_hi_in = '0;
               acc_lo_in = '0;
               den_in    = md_req.den;
               cnt_in    = '0;
            end
         end
         MD_MUL: begin
            acc_hi_in = mul_sum[TICK_W+1:2];
            acc_lo_in = {mul_sum[1:0], acc_lo_ff[MPLR_W-1:2]};
            mplr_in   = {2'b00, mplr_ff[MPLR_W-1:2]};
            cnt_in    = cnt_ff + 1'b1;
         end
         MD_ROUND: begin
            dv_hi_in = dsum[ACC_HI_W+MPLR_W-1:NS_W];
            dv_lo_in = dsum[NS_W-1:0];
         end
         MD_CHECK: begin
            if (sat) begin
               dv_lo_in = '1;
            end else begin
               rem_in = dv_hi_ff[TB_W-1:0];
            end
            cnt_in = '0;
         end
         MD_DIV: begin
            rem_in   = r2;
            dv_lo_in = {dv_lo_ff[NS_W-3:0], ge1, ge2};
            cnt_in   = cnt_ff + 1'b1;
         end
         MD_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      mag3_ff   <= mag3_in;
      mplr_ff   <= mplr_in;
      acc_hi_ff <= acc_hi_in;
      acc_lo_ff <= acc_lo_in;
      den_ff    <= den_in;
      dv_hi_ff  <= dv_hi_in;
      dv_lo_ff  <= dv_lo_in;
      rem_ff    <= rem_in;
   end

   assign md_rsp.busy = state_ff != MD_IDLE;
   assign md_rsp.done = state_ff == MD_DONE;
   assign md_rsp.quot = dv_lo_ff;

endmodule

/* test/tb_top.sv */
// self-checking testbench for frame_timestamp_repair: directed and random frame records
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ftr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned HOLD_CYCLES = 2000;
   localparam int unsigned PHASES      = 9;
   localparam int unsigned PHASE_ITEMS = 148;

   localparam logic signed [63:0] PTS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PTS_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [62:0] TICK_TOP    = 63'h3FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] TICK_BOTTOM = 63'h4000_0000_0000_0000;
   localparam logic [62:0] TICK_NEG1   = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] TICK_NEG3   = 63'h7FFF_FFFF_FFFF_FFFD;
   localparam logic [63:0] NS_SCALE    = 64'd1000000000;

   typedef struct {
      logic        mode;
      logic        ts_known;
      logic [62:0] ts_ticks;
      logic [31:0] dur_ticks;
      logic [15:0] sample_count;
   } frame_rec_type;

   typedef struct {
      logic signed [63:0] pts_ns;
      logic               pts_valid;
      logic signed [63:0] dur_ns;
   } timing_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TB_W-1:0] csr_wdata;

   ftr_req_if req_ch ();
   ftr_rsp_if rsp_ch ();

   frame_timestamp_repair dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_rec_type pending_frames[$];
   timing_type    expected_timing[$];

   // shadow configuration
   logic [30:0] vid_num = RST_VIDEO_TB_NUM;
   logic [30:0] vid_den = RST_VIDEO_TB_DEN;
   logic [30:0] aud_num = RST_AUDIO_TB_NUM;
   logic [30:0] aud_den = RST_AUDIO_TB_DEN;
   logic [19:0] aud_rate = RST_AUDIO_RATE;

   // stream history of the predictor
   logic signed [63:0] v_pred_ts = '0;
   logic               v_pred_ok = 1'b0;
   logic signed [63:0] v_last_ts = '0;
   logic               v_last_ok = 1'b0;
   logic signed [63:0] v_last_dur = '0;
   logic signed [63:0] a_pred_ts = '0;
   logic               a_pred_ok = 1'b0;

   logic [62:0] vid_tick = '0;
   logic [62:0] aud_tick = '0;

   logic          calm = 1'b0;
   int unsigned   req_gap;
   int unsigned   stall_left;
   int unsigned   hold_left;
   int unsigned   resp_gap;
   int unsigned   frames_taken;
   int unsigned   cycle_count = 0;
   int unsigned   error_count = 0;
   frame_rec_type next_frame;
   frame_rec_type seen_frame;
   timing_type    want;

   function automatic logic [63:0] scale_round(input logic [62:0] mag, input logic [63:0] mult,
                                               input logic [63:0] div);
      logic [127:0] acc;
      logic [127:0] quot;
      acc = {65'd0, mag} * {64'd0, mult};
      acc = acc + {65'd0, div[63:1]};
      quot = acc / {64'd0, div};
      return (quot[127:64] != '0) ? '1 : quot[63:0];
   endfunction

   function automatic logic signed [63:0] clamp_signed(input logic neg, input logic [63:0] q);
      if (!neg) begin
         return q[63] ? PTS_MAX : $signed(q);
      end
      if (q[63]) begin
         return PTS_MIN;
      end
      return -$signed(q);
   endfunction

   function automatic logic signed [63:0] ticks_to_ns(input logic neg, input logic [62:0] mag,
                                                      input logic [30:0] num,
                                                      input logic [30:0] den);
      logic [63:0] d;
      d = (den == '0) ? 64'd1 : {33'd0, den};
      return clamp_signed(neg, scale_round(mag, {33'd0, num} * NS_SCALE, d));
   endfunction

   function automatic logic signed [63:0] clip_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? PTS_MIN : PTS_MAX;
      end
      return $signed(s[63:0]);
   endfunction

   function automatic logic signed [63:0] clip_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? PTS_MIN : PTS_MAX;
      end
      return $signed(s[63:0]);
   endfunction

   function automatic timing_type repair_timing(input frame_rec_type f);
      logic               neg;
      logic [62:0]        mag;
      logic signed [63:0] pts;
      logic signed [63:0] dur;
      logic               ok;
      timing_type         r;
      neg = f.ts_ticks[62];
      mag = neg ? (~f.ts_ticks + 63'd1) : f.ts_ticks;
      if (f.mode == MODE_VIDEO) begin
         if (f.ts_known) begin
            pts = ticks_to_ns(neg, mag, vid_num, vid_den);
            ok = 1'b1;
         end else begin
            pts = v_pred_ok ? v_pred_ts : '0;
            ok = v_pred_ok;
         end
         if (f.dur_ticks != '0) begin
            dur = ticks_to_ns(1'b0, {31'd0, f.dur_ticks}, vid_num, vid_den);
         end else if (v_last_ok && ok) begin
            dur = clip_sub(pts, v_last_ts);
         end else if (v_last_dur > 0) begin
            dur = v_last_dur;
         end else begin
            dur = ticks_to_ns(1'b0, 63'd1, vid_num, vid_den);
         end
         v_last_dur = dur;
         v_last_ts = ok ? pts : '0;
         v_last_ok = ok;
         v_pred_ts = ok ? clip_add(pts, dur) : '0;
         v_pred_ok = ok;
      end else begin
         if (f.ts_known) begin
            pts = ticks_to_ns(neg, mag, aud_num, aud_den);
            ok = 1'b1;
         end else begin
            pts = a_pred_ok ? a_pred_ts : '0;
            ok = a_pred_ok;
         end
         if (aud_rate == '0) begin
            dur = '0;
         end else begin
            dur = clamp_signed(1'b0, scale_round({47'd0, f.sample_count}, NS_SCALE,
                                                 {44'd0, aud_rate}));
         end
         a_pred_ts = ok ? clip_add(pts, dur) : '0;
         a_pred_ok = ok;
      end
      r.pts_ns = ok ? pts : '0;
      r.pts_valid = ok;
      r.dur_ns = dur;
      return r;
   endfunction

   function automatic frame_rec_type frame_of(input logic mode, input logic known,
                                              input logic [62:0] ts, input logic [31:0] dur,
                                              input logic [15:0] samples);
      frame_rec_type f;
      f.mode = mode;
      f.ts_known = known;
      f.ts_ticks = ts;
      f.dur_ticks = dur;
      f.sample_count = samples;
      return f;
   endfunction

   function automatic frame_rec_type random_frame();
      frame_rec_type f;
      int unsigned   kind;
      int unsigned   step;
      kind = $urandom_range(0, 99);
      step = $urandom_range(0, 3000);
      f.mode = 1'($urandom_range(0, 1));
      f.ts_known = ($urandom_range(0, 7) != 0);
      f.dur_ticks = $urandom;
      f.sample_count = 16'($urandom);
      f.ts_ticks = 63'({$urandom, $urandom});
      if (kind < 75) begin
         if (f.mode == MODE_VIDEO) begin
            f.ts_ticks = vid_tick;
            vid_tick = vid_tick + 63'(step);
            f.dur_ticks = ($urandom_range(0, 1) == 0) ? 32'd0 : step;
            if ($urandom_range(0, 19) == 0) begin
               vid_tick = vid_tick - 63'($urandom_range(1, 90000));
            end
         end else begin
            f.ts_ticks = aud_tick;
            aud_tick = aud_tick + 63'(step);
            f.sample_count = 16'($urandom_range(0, 2048));
         end
      end else if (kind < 88) begin
         f.ts_ticks = ($urandom_range(0, 1) == 0) ? TICK_TOP - 63'($urandom_range(0, 1000))
                                                  : TICK_BOTTOM + 63'($urandom_range(0, 1000));
      end
      return f;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic [30:0] pick_num();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 31'd1;
      if (r < 55) return 31'd1001;
      if (r < 80) return 31'($urandom_range(1, 1000));
      return 31'($urandom_range(1, 32'h7FFF_FFFF));
   endfunction

   function automatic logic [30:0] pick_den();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return 31'd90000;
      if (r < 35) return 31'($urandom_range(1, 100000));
      if (r < 45) return 31'd48000;
      if (r < 95) return 31'($urandom_range(1, 32'h7FFF_FFFF));
      return 31'd0;
   endfunction

   function automatic logic [30:0] pick_rate();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return 31'd1;
      if (r < 25) return 31'd48000;
      if (r < 40) return 31'd44100;
      if (r < 88) return 31'($urandom_range(1, 768000));
      if (r < 95) return 31'd768000;
      return 31'd0;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   task automatic set_reg(input ftr_csr_idx_type idx, input logic [30:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VIDEO_TB_NUM: vid_num = val;
         CSR_VIDEO_TB_DEN: vid_den = val;
         CSR_AUDIO_TB_NUM: aud_num = val;
         CSR_AUDIO_TB_DEN: aud_den = val;
         CSR_AUDIO_RATE:   aud_rate = val[19:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_frames.size() != 0 || expected_timing.size() != 0 || req_ch.valid);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= 0;
         frames_taken <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            seen_frame.mode = req_ch.mode;
            seen_frame.ts_known = req_ch.ts_known;
            seen_frame.ts_ticks = req_ch.ts_ticks;
            seen_frame.dur_ticks = req_ch.dur_ticks;
            seen_frame.sample_count = req_ch.sample_count;
            expected_timing.push_back(repair_timing(seen_frame));
            frames_taken <= frames_taken + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               next_frame = pending_frames.pop_front();
               req_ch.mode <= next_frame.mode;
               req_ch.ts_known <= next_frame.ts_known;
               req_ch.ts_ticks <= next_frame.ts_ticks;
               req_ch.dur_ticks <= next_frame.dur_ticks;
               req_ch.sample_count <= next_frame.sample_count;
               req_ch.valid <= 1'b1;
               req_gap <= calm ? 0 : pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (req_ch.valid && req_ch.ready && (frames_taken == 200 || frames_taken == 960)) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_timing.size() == 0) begin
               note_error($sformatf("unexpected transaction: pts_valid %0b pts_ns %0d dur_ns %0d",
                                    rsp_ch.pts_valid, rsp_ch.pts_ns, rsp_ch.dur_ns));
            end else begin
               want = expected_timing.pop_front();
               if (rsp_ch.pts_valid !== want.pts_valid || rsp_ch.pts_ns !== want.pts_ns ||
                   rsp_ch.dur_ns !== want.dur_ns) begin
                  note_error($sformatf({"mismatch: expected pts_valid %0b pts_ns %0d dur_ns %0d,",
                                        " got pts_valid %0b pts_ns %0d dur_ns %0d"},
                                       want.pts_valid, want.pts_ns, want.dur_ns,
                                       rsp_ch.pts_valid, rsp_ch.pts_ns, rsp_ch.dur_ns));
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            resp_gap = calm ? 0 : pick_gap();
            stall_left <= resp_gap;
            rsp_ch.ready <= (resp_gap == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default time bases: no prediction yet, saturation at both ends, negative gaps
      @(negedge clock);
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b0, '0, 32'd0, 16'd1024));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, '0, 32'd0, 16'hFFFF));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, 63'd3000, 32'hFFFF_FFFF, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, TICK_TOP, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, TICK_BOTTOM, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, TICK_NEG1, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, TICK_NEG1, 32'hFFFF_FFFF, 16'hFFFF));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, TICK_TOP, 32'd0, 16'd1));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b0, '0, 32'd0, 16'd1));
      wait_idle();

      // half-tick rounding, zero denominator, zero sample rate
      set_reg(CSR_VIDEO_TB_NUM, 31'd1);
      set_reg(CSR_VIDEO_TB_DEN, 31'd2000000000);
      set_reg(CSR_AUDIO_TB_NUM, 31'h7FFF_FFFF);
      set_reg(CSR_AUDIO_TB_DEN, 31'd0);
      set_reg(CSR_AUDIO_RATE, 31'd0);
      @(negedge clock);
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, 63'd1, 32'd1, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, TICK_NEG1, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, 63'd3, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, 63'd1, 32'd0, 16'hFFFF));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, TICK_NEG3, 32'd0, 16'd5));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, 63'd5, 32'd0, 16'd5));
      wait_idle();

      // widest time bases and fastest sample rate
      set_reg(CSR_VIDEO_TB_NUM, 31'h7FFF_FFFF);
      set_reg(CSR_VIDEO_TB_DEN, 31'd1);
      set_reg(CSR_AUDIO_TB_NUM, 31'd1);
      set_reg(CSR_AUDIO_TB_DEN, 31'h7FFF_FFFF);
      set_reg(CSR_AUDIO_RATE, 31'd768000);
      @(negedge clock);
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b1, 63'd1, 32'hFFFF_FFFF, 16'd0));
      pending_frames.push_back(frame_of(MODE_VIDEO, 1'b0, '0, 32'd0, 16'd0));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b1, TICK_BOTTOM, 32'd0, 16'hFFFF));
      pending_frames.push_back(frame_of(MODE_AUDIO, 1'b0, '0, 32'd0, 16'd1));
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         set_reg(CSR_VIDEO_TB_NUM, pick_num());
         set_reg(CSR_VIDEO_TB_DEN, pick_den());
         set_reg(CSR_AUDIO_TB_NUM, pick_num());
         set_reg(CSR_AUDIO_TB_DEN, pick_den());
         set_reg(CSR_AUDIO_RATE, pick_rate());
         @(negedge clock);
         calm = ($urandom_range(0, 3) == 0);
         vid_tick = 63'($urandom) - 63'h8000_0000;
         aud_tick = 63'($urandom) - 63'h8000_0000;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_frames.push_back(random_frame());
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
